### rtl/core/dlm_pkg.sv
`default_nettype none

package dlm_pkg;

    // Data path widths: Q16.16 words and the wide accumulator.
    localparam int DATA_W     = 32;
    localparam int ACC_W      = 64;
    localparam int FRAC_W     = 16;
    localparam int OPCODE_W   = 3;
    localparam int NEURON_W   = 6;
    localparam int SLOT_W     = 6;
    localparam int COUNT_W    = 7;
    localparam int RATE_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PREV_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 2'd2;

    // Configuration values after reset.
    localparam logic [COUNT_W-1:0] RST_PREV_COUNT    = 7'd64;
    localparam logic [COUNT_W-1:0] RST_WEIGHT_COUNT  = 7'd64;
    localparam logic [RATE_W-1:0]  RST_LEARNING_RATE = 16'd655;

    // Saturation bounds of a signed 32-bit word, held at accumulator width.
    localparam logic signed [ACC_W-1:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [ACC_W-1:0] SAT_LO = 64'shFFFF_FFFF_8000_0000;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD_INPUT  = 3'd0,
        OP_LOAD_WEIGHT = 3'd1,
        OP_LOAD_BIAS   = 3'd2,
        OP_FORWARD     = 3'd3,
        OP_UPDATE      = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_PREP,
        S_WALK,
        S_DRAIN,
        S_BIAS_WB,
        S_DONE
    } t_state;

    // Controls of the shared multiply-accumulate unit.
    typedef struct packed {
        logic acc_load;
        logic acc_add;
    } t_mac_ctrl;

    // Clamp a wide signed value into a signed 32-bit word.
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [DATA_W-1:0] res;
        if (x > SAT_HI) begin
            res = SAT_HI[DATA_W-1:0];
        end else if (x < SAT_LO) begin
            res = SAT_LO[DATA_W-1:0];
        end else begin
            res = x[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/core/dlm_in_if.sv
`default_nettype none

interface dlm_in_if;
    import dlm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OPCODE_W-1:0]      opcode;
    logic [NEURON_W-1:0]      neuron;
    logic [SLOT_W-1:0]        slot;
    logic signed [DATA_W-1:0] operand;

    modport source (output valid, opcode, neuron, slot, operand, input ready);
    modport sink   (input valid, opcode, neuron, slot, operand, output ready);
endinterface

`default_nettype wire

### rtl/core/dlm_out_if.sv
`default_nettype none

interface dlm_out_if;
    import dlm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     status;
    logic signed [DATA_W-1:0] weighted_sum;

    modport source (output valid, status, weighted_sum, input ready);
    modport sink   (input valid, status, weighted_sum, output ready);
endinterface

`default_nettype wire

### rtl/core/dense_layer_mac_sgd.sv
// Loads, unknown opcodes, and a forward or update with unequal counts go from decode straight
// to the done state and a result word. Forward and update first walk a row of n elements,
// n being prev_count capped at MAX_INPUTS; one row element passes the shared unit per cycle.
// The next word is accepted once the sequencer is back in idle, even while the last result
// word still waits in the output register.
// Synchronous active-low reset restores configuration and control; memories are not cleared.
`default_nettype none

module dense_layer_mac_sgd #(
    parameter int MAX_NEURONS = 64,
    parameter int MAX_INPUTS  = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [dlm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [dlm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    dlm_in_if.sink                                 i_in,
    dlm_out_if.source                              o_out
);
    import dlm_pkg::*;

    localparam int WDEPTH = MAX_NEURONS * MAX_INPUTS;
    localparam int IW     = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int NW     = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
    localparam int WW     = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int CW     = $clog2(MAX_INPUTS + 1);

    // Configuration registers.
    logic [COUNT_W-1:0] r_prev_count;
    logic [COUNT_W-1:0] r_weight_count;
    logic [RATE_W-1:0]  r_lr;

    // Sequencer and the captured word.
    t_state                   r_state, n_state;
    logic [OPCODE_W-1:0]      r_op;
    logic [NEURON_W-1:0]      r_nr;
    logic [SLOT_W-1:0]        r_sl;
    logic signed [DATA_W-1:0] r_val;
    logic [CW-1:0]            r_j;
    logic                     r_v1, r_v2;
    logic [WW-1:0]            r_k1, r_k2;
    logic signed [DATA_W-1:0] r_g;
    logic                     r_status_q;
    logic                     r_use_acc;

    // Output register.
    logic                     r_out_valid;
    logic                     r_out_status;
    logic signed [DATA_W-1:0] r_out_sum;

    // Memories and their registered read data.
    logic signed [DATA_W-1:0] r_wmem [WDEPTH];
    logic signed [DATA_W-1:0] r_amem [MAX_INPUTS];
    logic signed [DATA_W-1:0] r_bmem [MAX_NEURONS];
    logic signed [DATA_W-1:0] r_w_rd, r_a_rd, r_b_rd;

    // Combinational controls.
    logic                     mismatch, nr_ok, sl_ok;
    logic [CW-1:0]            n_lim;
    logic [WW-1:0]            issue_addr, load_addr;
    logic                     issue;
    logic                     w_we;
    logic [WW-1:0]            w_waddr;
    logic signed [DATA_W-1:0] w_wdata;
    logic                     a_we;
    logic                     b_we, b_re;
    logic signed [DATA_W-1:0] b_wdata;
    logic                     out_load;
    t_mac_ctrl                mac_ctrl;
    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic signed [ACC_W-1:0]  mac_shifted, mac_acc;
    logic signed [DATA_W-1:0] mac_diff;

    assign mismatch   = (r_prev_count != r_weight_count);
    assign nr_ok      = (32'(r_nr) < 32'(MAX_NEURONS));
    assign sl_ok      = (32'(r_sl) < 32'(MAX_INPUTS));
    assign n_lim      = (32'(r_prev_count) < 32'(MAX_INPUTS)) ? CW'(r_prev_count)
                                                              : CW'(MAX_INPUTS);
    assign issue_addr = WW'(32'(r_nr) * 32'(MAX_INPUTS) + 32'(r_j));
    assign load_addr  = WW'(32'(r_nr) * 32'(MAX_INPUTS) + 32'(r_sl));

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_count   <= RST_PREV_COUNT;
            r_weight_count <= RST_WEIGHT_COUNT;
            r_lr           <= RST_LEARNING_RATE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PREV_COUNT:    r_prev_count   <= i_cfg_data[COUNT_W-1:0];
                CFG_WEIGHT_COUNT:  r_weight_count <= i_cfg_data[COUNT_W-1:0];
                CFG_LEARNING_RATE: r_lr           <= i_cfg_data[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // Next state and memory controls.
    always_comb begin
        n_state  = r_state;
        issue    = 1'b0;
        w_we     = 1'b0;
        w_waddr  = load_addr;
        w_wdata  = r_val;
        a_we     = 1'b0;
        b_we     = 1'b0;
        b_re     = 1'b0;
        b_wdata  = r_val;
        out_load = 1'b0;
        mac_ctrl = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                case (r_op)
                    OP_LOAD_INPUT:  a_we = sl_ok;
                    OP_LOAD_WEIGHT: w_we = nr_ok && sl_ok;
                    OP_LOAD_BIAS:   b_we = nr_ok;
                    OP_FORWARD, OP_UPDATE: begin
                        if (!mismatch && nr_ok) begin
                            b_re    = 1'b1;
                            n_state = S_PREP;
                        end
                    end
                    default: ;
                endcase
            end
            S_PREP: begin
                mac_ctrl.acc_load = (r_op == OP_FORWARD);
                n_state           = S_WALK;
            end
            S_WALK: begin
                if (r_j < n_lim) begin
                    issue = 1'b1;
                end else begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = (r_op == OP_UPDATE) ? S_BIAS_WB : S_DONE;
                end
            end
            S_BIAS_WB: begin
                b_we    = 1'b1;
                b_wdata = sat32(ACC_W'(r_b_rd) - ACC_W'(r_g));
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Last pipeline stage: accumulate for forward, write back for update.
        mac_ctrl.acc_add = r_v2 && (r_op == OP_FORWARD);
        if (r_v2 && (r_op == OP_UPDATE)) begin
            w_we    = 1'b1;
            w_waddr = r_k2;
            w_wdata = mac_diff;
        end
    end

    // State register and element pipeline flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= issue;
            r_v2    <= r_v1;
        end
    end

    // Captured word, element counter and step size.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_op  <= i_in.opcode;
            r_nr  <= i_in.neuron;
            r_sl  <= i_in.slot;
            r_val <= i_in.operand;
        end
        if (r_state == S_DECODE) begin
            r_j        <= '0;
            r_status_q <= ((r_op == OP_FORWARD) || (r_op == OP_UPDATE)) && mismatch;
            r_use_acc  <= (r_op == OP_FORWARD) && !mismatch && nr_ok;
        end else if (issue) begin
            r_j <= r_j + CW'(1);
        end
        if (r_state == S_PREP) begin
            r_g <= mac_shifted[DATA_W-1:0];
        end
        if (issue) begin
            r_k1 <= issue_addr;
        end
        r_k2 <= r_k1;
    end

    // Weight memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_wmem[w_waddr] <= w_wdata;
        end
        if (issue) begin
            r_w_rd <= r_wmem[issue_addr];
        end
    end

    // Activation memory.
    always_ff @(posedge i_clk) begin
        if (a_we) begin
            r_amem[IW'(r_sl)] <= r_val;
        end
        if (issue) begin
            r_a_rd <= r_amem[r_j[IW-1:0]];
        end
    end

    // Bias memory.
    always_ff @(posedge i_clk) begin
        if (b_we) begin
            r_bmem[NW'(r_nr)] <= b_wdata;
        end
        if (b_re) begin
            r_b_rd <= r_bmem[NW'(r_nr)];
        end
    end

    // Operand selection: the step size product first, then one element per cycle.
    always_comb begin
        if (r_state == S_DECODE) begin
            mul_a = {{(DATA_W - RATE_W){1'b0}}, r_lr};
            mul_b = r_val;
        end else begin
            mul_a = (r_op == OP_UPDATE) ? r_g : r_w_rd;
            mul_b = r_a_rd;
        end
    end

    dlm_mac u_mac (
        .i_clk     (i_clk),
        .i_ctrl    (mac_ctrl),
        .i_mul_a   (mul_a),
        .i_mul_b   (mul_b),
        .i_sub     (r_w_rd),
        .i_init    (r_b_rd),
        .o_shifted (mac_shifted),
        .o_acc     (mac_acc),
        .o_diff    (mac_diff)
    );

    // Output register holds a word until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= r_status_q;
            r_out_sum    <= r_use_acc ? sat32(mac_acc) : '0;
        end
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out_status;
    assign o_out.weighted_sum = r_out_sum;

    // The element counter never runs past the row length.
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_j <= n_lim))
        else $error("element counter ran past the row length");

    // Results of the element pipeline only arrive while a row is being walked.
    a_pipe_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> ((r_state == S_WALK) || (r_state == S_DRAIN)))
        else $error("element pipeline active outside a row walk");

    // An accepted word is always decoded in the next cycle.
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_DECODE))
        else $error("accepted word was not decoded");

    // The accumulator is never preset and advanced in the same cycle.
    a_acc_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mac_ctrl.acc_load && mac_ctrl.acc_add))
        else $error("accumulator preset collides with an element");

endmodule

`default_nettype wire

### rtl/core/dlm_mac.sv
`default_nettype none

// Shared multiply-accumulate unit: one registered 32x32 product, a floor
// shift back to Q16.16, an accumulator and a saturating subtract.
module dlm_mac (
    input  wire logic                             i_clk,
    input  wire dlm_pkg::t_mac_ctrl               i_ctrl,
    input  wire logic signed [dlm_pkg::DATA_W-1:0] i_mul_a,
    input  wire logic signed [dlm_pkg::DATA_W-1:0] i_mul_b,
    input  wire logic signed [dlm_pkg::DATA_W-1:0] i_sub,
    input  wire logic signed [dlm_pkg::DATA_W-1:0] i_init,
    output logic signed [dlm_pkg::ACC_W-1:0]       o_shifted,
    output logic signed [dlm_pkg::ACC_W-1:0]       o_acc,
    output logic signed [dlm_pkg::DATA_W-1:0]      o_diff
);
    import dlm_pkg::*;

    logic signed [ACC_W-1:0]  r_prod;
    logic signed [DATA_W-1:0] r_sub;
    logic signed [ACC_W-1:0]  r_acc;

    // Product stage; the minuend travels alongside so both line up.
    always_ff @(posedge i_clk) begin
        r_prod <= ACC_W'(i_mul_a) * ACC_W'(i_mul_b);
        r_sub  <= i_sub;
    end

    // An arithmetic shift rounds toward minus infinity.
    assign o_shifted = r_prod >>> FRAC_W;

    // Accumulator: preset from the bias, then one term per element.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.acc_load) begin
            r_acc <= ACC_W'(i_init);
        end else if (i_ctrl.acc_add) begin
            r_acc <= r_acc + o_shifted;
        end
    end

    assign o_acc  = r_acc;
    assign o_diff = sat32(ACC_W'(r_sub) - o_shifted);

endmodule

`default_nettype wire
